FILE: rtl/ncoe_pkg.sv
package ncoe_pkg;

    // Fixed geometry of the register map and of one request
    localparam int NUM_DIMS       = 5;
    localparam int SIZE_BITS      = 16;
    localparam int RANK_BITS      = 3;
    localparam int KIND_BITS      = 3;
    localparam int ELEM_BITS      = 64;
    localparam int PADDR_BITS     = 5;
    localparam int PDATA_BITS     = 32;
    localparam int REG_IDX_BITS   = 3;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_RANK   = 5;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_COUNT_BITS = 40;

    // Front-to-back queue
    localparam int QDEPTH         = 4;
    localparam int QPTR_BITS      = $clog2(QDEPTH);

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_RANK  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE0 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE1 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE2 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE3 = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE4 = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_KIND  = 3'd6;

    // Element kinds
    localparam logic [KIND_BITS-1:0] KIND_INT  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_F32  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_F64  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_C64  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_HALF = 3'd4;

    typedef logic [SIZE_BITS-1:0] size_t;

    typedef struct packed {
        logic [RANK_BITS-1:0]       rank;
        size_t [NUM_DIMS-1:0]       size;
        logic [KIND_BITS-1:0]       kind;
    } cfg_t;

    // One classified request on its way from front to back
    typedef struct packed {
        logic                       hit;
        logic                       done;
        size_t [NUM_DIMS-1:0]       coord;
    } entry_t;

endpackage

FILE: rtl/ncoe_regs.sv
module ncoe_regs
    import ncoe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [REG_IDX_BITS-1:0] idx;
    logic                    wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_BITS-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RANK:  cfg_next.rank    = pwdata[RANK_BITS-1:0];
                REG_SIZE0: cfg_next.size[0] = pwdata[SIZE_BITS-1:0];
                REG_SIZE1: cfg_next.size[1] = pwdata[SIZE_BITS-1:0];
                REG_SIZE2: cfg_next.size[2] = pwdata[SIZE_BITS-1:0];
                REG_SIZE3: cfg_next.size[3] = pwdata[SIZE_BITS-1:0];
                REG_SIZE4: cfg_next.size[4] = pwdata[SIZE_BITS-1:0];
                REG_KIND:  cfg_next.kind    = pwdata[KIND_BITS-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RANK:  prdata = PDATA_BITS'(cfg_reg.rank);
            REG_SIZE0: prdata = PDATA_BITS'(cfg_reg.size[0]);
            REG_SIZE1: prdata = PDATA_BITS'(cfg_reg.size[1]);
            REG_SIZE2: prdata = PDATA_BITS'(cfg_reg.size[2]);
            REG_SIZE3: prdata = PDATA_BITS'(cfg_reg.size[3]);
            REG_SIZE4: prdata = PDATA_BITS'(cfg_reg.size[4]);
            REG_KIND:  prdata = PDATA_BITS'(cfg_reg.kind);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank <= RANK_BITS'(1);
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                cfg_reg.size[d] <= SIZE_BITS'(1);
            end
            cfg_reg.kind <= KIND_INT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/ncoe_front.sv
module ncoe_front
    import ncoe_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 push,
    input  logic                 full,
    input  logic [ELEM_BITS-1:0] element_bits,
    output logic                 q_push,
    output entry_t               q_entry
);

    localparam int RANK_LIM = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

    size_t                   pos_reg  [NUM_DIMS];
    size_t                   pos_next [NUM_DIMS];
    size_t                   ext      [NUM_DIMS];
    logic [SIZE_BITS:0]      pos_inc  [NUM_DIMS];
    logic [NUM_DIMS-1:0]     wrap;
    logic [NUM_DIMS-1:0]     used;
    logic [RANK_BITS-1:0]    rank_eff;
    logic                    nonzero;
    logic                    in_range;
    logic                    done;
    logic                    accept;

    assign accept = push & ~full;

    // rank zero counts as one, large ranks clamp
    always_comb
    begin
        priority if (cfg.rank == '0)
            rank_eff = RANK_BITS'(1);
        else if (cfg.rank > RANK_BITS'(RANK_LIM))
            rank_eff = RANK_BITS'(RANK_LIM);
        else
            rank_eff = cfg.rank;
    end

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            used[d]    = (RANK_BITS'(d) < rank_eff);
            ext[d]     = (cfg.size[d] == '0) ? SIZE_BITS'(1) : cfg.size[d];
            pos_inc[d] = {1'b0, pos_reg[d]} + 1'b1;
            wrap[d]    = (pos_inc[d] >= {1'b0, ext[d]});
        end
    end

    // Odometer: innermost used digit first, carry ripples outwards
    always_comb
    begin
        logic carry;
        carry    = 1'b1;
        in_range = 1'b1;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            if (used[d])
            begin
                if (pos_reg[d] >= ext[d])
                begin
                    in_range = 1'b0;
                end
                if (carry)
                begin
                    pos_next[d] = wrap[d] ? '0 : pos_inc[d][SIZE_BITS-1:0];
                end
                else
                begin
                    pos_next[d] = pos_reg[d];
                end
                carry = carry & wrap[d];
            end
            else
            begin
                pos_next[d] = '0;
            end
        end
        done = carry;
    end

    // Zero test per element kind; sign bits ignored for floats
    always_comb
    begin
        unique case (cfg.kind)
            KIND_F32:  nonzero = |element_bits[30:0];
            KIND_F64:  nonzero = |element_bits[62:0];
            KIND_C64:  nonzero = (|element_bits[30:0]) | (|element_bits[62:32]);
            KIND_HALF: nonzero = |element_bits[14:0];
            default:   nonzero = |element_bits;
        endcase
    end

    always_comb
    begin
        q_entry.hit  = in_range & nonzero;
        q_entry.done = done;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            q_entry.coord[d] = used[d] ? pos_reg[d] : '0;
        end
    end

    assign q_push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else if (accept)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                pos_reg[d] <= pos_next[d];
            end
        end
    end

endmodule

FILE: rtl/ncoe_queue.sv
module ncoe_queue
    import ncoe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_data,
    input  logic   rd,
    output entry_t rd_data,
    output logic   empty,
    output logic   full
);

    entry_t                mem [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QPTR_BITS:0]    count_reg;
    logic [QPTR_BITS:0]    count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/ncoe_back.sv
module ncoe_back
    import ncoe_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  entry_t                head,
    input  logic                  head_empty,
    output logic                  head_take,
    input  logic                  pop,
    output logic                  empty,
    output logic                  is_hit,
    output logic [COUNT_BITS-1:0] row_index,
    output logic [COORD_BITS-1:0] coord [NUM_DIMS],
    output logic                  tensor_done,
    output logic [COUNT_BITS-1:0] total_hits
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    logic                  done_reg;
    logic [COUNT_BITS-1:0] row_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COORD_BITS-1:0] coord_reg [NUM_DIMS];
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [COUNT_BITS-1:0] total;
    logic                  needs_out;
    logic                  slot_free;
    logic                  load;

    assign needs_out = head.hit | head.done;
    assign slot_free = ~out_valid_reg | pop;
    // requests without a result drain regardless of the output slot
    assign head_take = ~head_empty & (~needs_out | slot_free);
    assign load      = head_take & needs_out;

    assign cnt_sat  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign total    = head.hit ? cnt_sat : cnt_reg;
    assign cnt_next = head.done ? '0 : total;

    always_comb
    begin
        priority if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign empty       = ~out_valid_reg;
    assign is_hit      = hit_reg;
    assign row_index   = row_reg;
    assign tensor_done = done_reg;
    assign total_hits  = total_reg;
    assign coord       = coord_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg   <= head.hit;
            done_reg  <= head.done;
            row_reg   <= head.hit ? cnt_reg : '0;
            total_reg <= total;
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                coord_reg[d] <= COORD_BITS'(head.coord[d]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (head_take)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

FILE: rtl/nonzero_coordinate_emitter_core.sv
// Channel   Handshake                        Payload
// -------   ------------------------------   ------------------------------------------
// input     push / full                      element_bits
// result    empty / pop                      is_hit, row_index, coord_0..4,
//                                            tensor_done, total_hits
// config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One request per cycle sustained while full stays low; a taken request passes the
// queue and then the result register on its way to the result ports. The odometer advances
// in the front in the accepting cycle; the hit count lives in the back and updates once per
// request. A four-entry queue parts the two, so a stalled result only blocks the input once
// the queue has filled. Reset leaves rank 1, all extents 1, integer elements,
// odometer and count at zero, and no result waiting.
module nonzero_coordinate_emitter_core
    import ncoe_pkg::*;
#(
    parameter int MAX_RANK   = DEF_MAX_RANK,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  push,
    output logic                  full,
    input  logic [ELEM_BITS-1:0]  element_bits,

    output logic                  empty,
    input  logic                  pop,
    output logic                  is_hit,
    output logic [COUNT_BITS-1:0] row_index,
    output logic [COORD_BITS-1:0] coord_0,
    output logic [COORD_BITS-1:0] coord_1,
    output logic [COORD_BITS-1:0] coord_2,
    output logic [COORD_BITS-1:0] coord_3,
    output logic [COORD_BITS-1:0] coord_4,
    output logic                  tensor_done,
    output logic [COUNT_BITS-1:0] total_hits,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    cfg_t                  cfg;
    entry_t                f_entry;
    entry_t                q_head;
    logic                  f_push;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_take;
    logic [COORD_BITS-1:0] coord [NUM_DIMS];

    // configuration registers
    ncoe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front: odometer and zero test, one request per cycle while the queue is not full
    ncoe_front #(
        .MAX_RANK (MAX_RANK)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .push         (push),
        .full         (q_full),
        .element_bits (element_bits),
        .q_push       (f_push),
        .q_entry      (f_entry)
    );

    // short queue between front and back
    ncoe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_entry),
        .rd      (q_take),
        .rd_data (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    // back: hit numbering and the result register
    ncoe_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_empty  (q_empty),
        .head_take   (q_take),
        .pop         (pop),
        .empty       (empty),
        .is_hit      (is_hit),
        .row_index   (row_index),
        .coord       (coord),
        .tensor_done (tensor_done),
        .total_hits  (total_hits)
    );

    assign full    = q_full;
    assign coord_0 = coord[0];
    assign coord_1 = coord[1];
    assign coord_2 = coord[2];
    assign coord_3 = coord[3];
    assign coord_4 = coord[4];

`ifndef SYNTHESIS
    // a result exists only for a hit or for the tensor's last element
    a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_hit || tensor_done))
        else $error("result with neither hit nor tensor end");

    // a miss carries row 0
    a_miss_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_hit) |-> (row_index == '0))
        else $error("miss result with nonzero row");

    // below saturation the running count is one past the row number
    a_count_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_hit && row_index != '1)
            |-> (total_hits == COUNT_BITS'(row_index + 1'b1)))
        else $error("total count does not follow row number");

    // the front never writes a full queue
    a_queue_guard: assert property (@(posedge clk) disable iff (!rst_n)
        !(f_push && q_full))
        else $error("queue overrun");
`endif

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import ncoe_pkg::*;

    localparam int CNT_W        = DEF_COUNT_BITS;
    localparam int CRD_W        = DEF_COORD_BITS;
    // Kind code above the defined range; the block treats it like integer.
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 3'd7;
    // Covers the four-entry queue and the result register, with margin.
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 48;
    localparam int QUIET_LIMIT  = 2000;
    localparam int NUM_PHASES   = 17;
    localparam int PRESSURE_PHASE = 4;
    localparam int NUM_DIRECTED = 24;

    // One result request as it leaves the block
    typedef struct packed {
        logic                            hit;
        logic [CNT_W-1:0]                row;
        logic [NUM_DIMS-1:0][CRD_W-1:0]  coord;
        logic                            done;
        logic [CNT_W-1:0]                total;
    } hit_record_t;

    // Directed row: tensor shape (dims 2..4 stay at extent 1), element and,
    // for single-element tensors, the hit flag read straight off the rules.
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [RANK_BITS-1:0]  rank;
        logic [SIZE_BITS-1:0]  sz0;
        logic [SIZE_BITS-1:0]  sz1;
        logic [ELEM_BITS-1:0]  bits;
        logic                  typed;
        logic                  hit;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [ELEM_BITS-1:0]   element_bits = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   is_hit;
    logic [CNT_W-1:0]       row_index;
    logic [CRD_W-1:0]       coord_0;
    logic [CRD_W-1:0]       coord_1;
    logic [CRD_W-1:0]       coord_2;
    logic [CRD_W-1:0]       coord_3;
    logic [CRD_W-1:0]       coord_4;
    logic                   tensor_done;
    logic [CNT_W-1:0]       total_hits;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    // Shadow of the register file and of the odometer / nonzero count
    logic [RANK_BITS-1:0]               cfg_rank = 3'd1;
    logic [NUM_DIMS-1:0][SIZE_BITS-1:0] cfg_size = {NUM_DIMS{16'd1}};
    logic [KIND_BITS-1:0]               cfg_kind = KIND_INT;
    int                                 odo_pos [NUM_DIMS] = '{default: 0};
    logic [CNT_W-1:0]                   nz_seen = '0;

    hit_record_t pending_hits [$];

    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    // Single-element tensors first (every element is also the final one),
    // then a 2x3 tensor whose trailing zero gives a final result with no hit.
    dir_row_t dir_tab [NUM_DIRECTED] = '{
        '{KIND_INT,     3'd1, 16'd1, 16'd1, 64'h0,                  1'b1, 1'b0},
        '{KIND_INT,     3'd1, 16'd1, 16'd1, 64'h1,                  1'b1, 1'b1},
        '{KIND_INT,     3'd1, 16'd1, 16'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b1},
        '{KIND_INT,     3'd1, 16'd1, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
        '{KIND_F32,     3'd1, 16'd1, 16'd1, 64'h0000_0000_8000_0000, 1'b1, 1'b0},
        '{KIND_F32,     3'd1, 16'd1, 16'd1, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0},
        '{KIND_F32,     3'd1, 16'd1, 16'd1, 64'h0000_0000_7FC0_0000, 1'b1, 1'b1},
        '{KIND_F64,     3'd1, 16'd1, 16'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b0},
        '{KIND_F64,     3'd1, 16'd1, 16'd1, 64'h0000_0000_0000_0001, 1'b1, 1'b1},
        '{KIND_C64,     3'd1, 16'd1, 16'd1, 64'h8000_0000_8000_0000, 1'b1, 1'b0},
        '{KIND_C64,     3'd1, 16'd1, 16'd1, 64'h0000_0001_8000_0000, 1'b1, 1'b1},
        '{KIND_C64,     3'd1, 16'd1, 16'd1, 64'h8000_0000_0000_0001, 1'b1, 1'b1},
        '{KIND_HALF,    3'd1, 16'd1, 16'd1, 64'hFFFF_FFFF_FFFF_8000, 1'b1, 1'b0},
        '{KIND_HALF,    3'd1, 16'd1, 16'd1, 64'h0000_0000_0000_7FFF, 1'b1, 1'b1},
        '{KIND_UNKNOWN, 3'd1, 16'd1, 16'd1, 64'h0000_0000_8000_0000, 1'b1, 1'b1},
        '{KIND_UNKNOWN, 3'd1, 16'd1, 16'd1, 64'h0,                  1'b1, 1'b0},
        '{KIND_INT,     3'd0, 16'd0, 16'd1, 64'h5,                  1'b1, 1'b1},
        '{KIND_INT,     3'd7, 16'd1, 16'd1, 64'h0,                  1'b1, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h0,                  1'b0, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h3,                  1'b0, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h0,                  1'b0, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h0,                  1'b0, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h9,                  1'b0, 1'b0},
        '{KIND_INT,     3'd2, 16'd2, 16'd3, 64'h0,                  1'b0, 1'b0}
    };

    nonzero_coordinate_emitter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .element_bits (element_bits),
        .empty        (empty),
        .pop          (pop),
        .is_hit       (is_hit),
        .row_index    (row_index),
        .coord_0      (coord_0),
        .coord_1      (coord_1),
        .coord_2      (coord_2),
        .coord_3      (coord_3),
        .coord_4      (coord_4),
        .tensor_done  (tensor_done),
        .total_hits   (total_hits),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Zero test per element kind: sign bits never make an element nonzero;
    // NaN and infinities do. Unknown kinds fall back to any-bit-set.
    function automatic logic elem_nonzero(input logic [ELEM_BITS-1:0] b,
                                          input logic [KIND_BITS-1:0] kind);
        case (kind)
            KIND_F32:  return |b[30:0];
            KIND_F64:  return |b[62:0];
            KIND_C64:  return (|b[30:0]) || (|b[62:32]);
            KIND_HALF: return |b[14:0];
            default:   return |b;
        endcase
    endfunction

    // Works out the result (if any) of one accepted element and steps the
    // shadow odometer and nonzero count along.
    task automatic predict_argwhere(input logic [ELEM_BITS-1:0] b,
                                    output bit emits, output hit_record_t rec);
        int r;
        int ext [NUM_DIMS];
        bit in_range;
        bit last_elem;
        bit hit;

        r = int'(cfg_rank);
        if (r < 1)
            r = 1;
        if (r > DEF_MAX_RANK)
            r = DEF_MAX_RANK;
        in_range = 1'b1;
        last_elem = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            ext[d] = (cfg_size[d] == 0) ? 1 : int'(cfg_size[d]);
            if (d >= r)
                odo_pos[d] = 0;
            else
            begin
                // a stale digit (left over from larger extents) kills the hit
                if (odo_pos[d] >= ext[d])
                    in_range = 1'b0;
                if (odo_pos[d] + 1 < ext[d])
                    last_elem = 1'b0;
            end
        end

        hit = in_range && elem_nonzero(b, cfg_kind);
        rec = '0;
        if (hit)
        begin
            rec.row = nz_seen;
            if (nz_seen != {CNT_W{1'b1}})
                nz_seen++;
        end
        rec.hit = hit;
        for (int d = 0; d < NUM_DIMS; d++)
            rec.coord[d] = CRD_W'(odo_pos[d]);
        rec.done = last_elem;
        rec.total = nz_seen;
        emits = hit || last_elem;

        // innermost used digit first; an out-of-range digit wraps to zero
        for (int d = r - 1; d >= 0; d--)
        begin
            if (odo_pos[d] + 1 >= ext[d])
                odo_pos[d] = 0;
            else
            begin
                odo_pos[d]++;
                break;
            end
        end
        if (last_elem)
            nz_seen = '0;
    endtask

    // Zeros of the current kind (including signed zeros with junk in
    // the ignored bits), single set bits and fully random patterns.
    function automatic logic [ELEM_BITS-1:0] rand_element(input logic [KIND_BITS-1:0] kind);
        logic [ELEM_BITS-1:0] ignored;
        logic [ELEM_BITS-1:0] raw;

        raw = {$urandom, $urandom};
        case (kind)
            KIND_F32:  ignored = ~64'h0000_0000_7FFF_FFFF;
            KIND_F64:  ignored = 64'h8000_0000_0000_0000;
            KIND_C64:  ignored = ~64'h7FFF_FFFF_7FFF_FFFF;
            KIND_HALF: ignored = ~64'h0000_0000_0000_7FFF;
            default:   ignored = '0;
        endcase
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3:    return raw & ignored;
            4, 5, 6: return 64'd1 << $urandom_range(0, 63);
            default: return raw;
        endcase
    endfunction

    // Setup then access phase; psel is left high so back-to-back writes
    // never lower and raise it in one step. load_config releases the bus.
    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [PDATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [RANK_BITS-1:0] rank_v,
                               input logic [NUM_DIMS-1:0][SIZE_BITS-1:0] sz,
                               input logic [KIND_BITS-1:0] kind_v);
        apb_write(REG_RANK,  PDATA_BITS'(rank_v));
        apb_write(REG_SIZE0, PDATA_BITS'(sz[0]));
        apb_write(REG_SIZE1, PDATA_BITS'(sz[1]));
        apb_write(REG_SIZE2, PDATA_BITS'(sz[2]));
        apb_write(REG_SIZE3, PDATA_BITS'(sz[3]));
        apb_write(REG_SIZE4, PDATA_BITS'(sz[4]));
        apb_write(REG_KIND,  PDATA_BITS'(kind_v));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_rank = rank_v;
        cfg_size = sz;
        cfg_kind = kind_v;
    endtask

    // Offers one element, with random gaps first, and records the expected
    // result at the edge the request is taken. push stays high on return.
    task automatic offer_element(input logic [ELEM_BITS-1:0] bits, input bit typed,
                                 input hit_record_t typed_rec);
        hit_record_t rec;
        bit emits;

        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        element_bits <= bits;
        do
            @(posedge clk);
        while (full);
        predict_argwhere(bits, emits, rec);
        if (typed)
            pending_hits.push_back(typed_rec);
        else if (emits)
            pending_hits.push_back(rec);
    endtask

    // Idle point: every expected result out, then let requests that yield
    // no result clear the pipeline before registers are touched.
    task automatic settle();
        push <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t  %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result side: compare each popped request, then pick the next pop.
    always @(posedge clk)
    begin
        hit_record_t want;

        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_hits.size() == 0)
                begin
                    mismatches++;
                    $display("%0t  unexpected result: expected none, actual row %0h done %0b",
                             $time, row_index, tensor_done);
                end
                else
                begin
                    want = pending_hits.pop_front();
                    check_field("is_hit",      64'(want.hit),      64'(is_hit));
                    check_field("row_index",   64'(want.row),      64'(row_index));
                    check_field("coord_0",     64'(want.coord[0]), 64'(coord_0));
                    check_field("coord_1",     64'(want.coord[1]), 64'(coord_1));
                    check_field("coord_2",     64'(want.coord[2]), 64'(coord_2));
                    check_field("coord_3",     64'(want.coord[3]), 64'(coord_3));
                    check_field("coord_4",     64'(want.coord[4]), 64'(coord_4));
                    check_field("tensor_done", 64'(want.done),     64'(tensor_done));
                    check_field("total_hits",  64'(want.total),    64'(total_hits));
                end
            end
            // long hold-off so the internal queue fills and full rises
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long without any request taken on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t row;
        hit_record_t typed_rec;
        logic [NUM_DIMS-1:0][SIZE_BITS-1:0] sz;
        logic [RANK_BITS-1:0] rank_v;
        logic [KIND_BITS-1:0] kind_v;
        int n_items;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the first rows run on the reset register values.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = dir_tab[i];
            sz = {16'd1, 16'd1, 16'd1, row.sz1, row.sz0};
            if (row.kind != cfg_kind || row.rank != cfg_rank || sz != cfg_size)
            begin
                settle();
                load_config(row.rank, sz, row.kind);
            end
            typed_rec = '0;
            typed_rec.hit = row.hit;
            typed_rec.done = 1'b1;
            typed_rec.total = CNT_W'(row.hit);
            offer_element(row.bits, row.typed, typed_rec);
        end

        // Random phases, each with its own shape, kind and idling mix.
        // The odometer is not cleared between phases, so shrinking extents
        // mid-tensor leaves stale digits behind.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 60; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase

            rank_v = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 5));
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                case ($urandom_range(0, 15))
                    0:       sz[d] = 16'd0;
                    1:       sz[d] = 16'hFFFF;
                    default: sz[d] = 16'($urandom_range(1, 4));
                endcase
            end
            kind_v = 3'($urandom_range(0, 7));

            if (p == 0)
            begin
                // full rank, carries through every digit
                rank_v = 3'd5;
                sz = {NUM_DIMS{16'd2}};
            end
            else if (p == 1)
            begin
                // widest extent; the odometer climbs well past the next one
                rank_v = 3'd1;
                sz = {16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF};
            end
            else if (p == 2)
            begin
                // extent shrinks below the live position: stale coordinate
                rank_v = 3'd1;
                sz = {16'd1, 16'd1, 16'd1, 16'd1, 16'd3};
            end
            else if (p == PRESSURE_PHASE)
            begin
                kind_v = KIND_INT;
                sz = {NUM_DIMS{16'd2}};
            end
            load_config(rank_v, sz, kind_v);

            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            n_items = $urandom_range(40, 80);
            repeat (n_items) offer_element(rand_element(cfg_kind), 1'b0, '0);
        end

        settle();
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ncoe_pkg.sv
rtl/ncoe_regs.sv
rtl/ncoe_front.sv
rtl/ncoe_queue.sv
rtl/ncoe_back.sv
rtl/nonzero_coordinate_emitter_core.sv
bench/tb_top.sv
